/* src/mt19937_bounded_draw_defines.svh */
// Assertion macros for the file that carries concurrent checks.
// Each macro expects the module to have a clock named clock and a reset named reset.
`ifndef MT19937_BOUNDED_DRAW_DEFINES_SVH
`define MT19937_BOUNDED_DRAW_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTBD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mtbd_pkg.sv */
`timescale 1ns / 1ps
package mtbd_pkg;

   localparam int MT_N = 624;
   localparam int MT_M = 397;
   localparam int MT_NM = 227;
   localparam int IDX_W = 10;

   localparam logic [31:0] SEED_MULT = 32'd1812433253;
   localparam logic [31:0] ARRAY_INIT_SEED = 32'd19650218;
   localparam logic [31:0] KEY_MULT = 32'd1664525;
   localparam logic [31:0] MIX_MULT = 32'd1566083941;
   localparam logic [31:0] MATRIX_A = 32'h9908b0df;
   localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C = 32'hefc60000;
   localparam logic [31:0] UPPER_MASK = 32'h80000000;
   localparam logic [31:0] LOWER_MASK = 32'h7fffffff;

   localparam logic FUNC_RESTART = 1'b0;
   localparam logic FUNC_DRAW = 1'b1;
   localparam logic SEED_SINGLE = 1'b0;
   localparam logic SEED_ARRAY = 1'b1;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_UNSEEDED = 1'b1;
   localparam logic REG_SEED_VALUE = 1'b0;
   localparam logic REG_SEED_MODE = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] limit;
   } req_data_type;

   typedef struct packed {
      logic [31:0] value;
      logic        status;
   } rsp_data_type;

   typedef enum logic [1:0] {
      COEF_SEED = 2'd0,
      COEF_KEY  = 2'd1,
      COEF_MIX  = 2'd2
   } coef_sel_type;

   typedef struct packed {
      logic         load;
      coef_sel_type sel;
      logic [31:0]  word;
   } mul_req_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [31:0]      data;
   } ram_wr_type;

   function automatic logic [31:0] twist_word(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] far);
      logic [31:0] y;
      y = (a & UPPER_MASK) | (b & LOWER_MASK);
      return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
   endfunction

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic [31:0] cover_mask(input logic [31:0] limit);
      logic [31:0] m;
      m = limit;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      m = m | (m >> 16);
      return m;
   endfunction

endpackage

/* src/mtbd_word_ram.sv */
`timescale 1ns / 1ps
module mtbd_word_ram
   import mtbd_pkg::*;
(
   input  logic             clock,
   input  ram_wr_type       wr,
   input  logic [IDX_W-1:0] rd_addr_a,
   input  logic [IDX_W-1:0] rd_addr_b,
   output logic [31:0]      rd_data_a,
   output logic [31:0]      rd_data_b
);

   logic [31:0] word_mem [0:MT_N-1];
   logic [31:0] rd_data_a_ff;
   logic [31:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         word_mem[wr.addr] <= wr.data;
      end
      rd_data_a_ff <= word_mem[rd_addr_a];
      rd_data_b_ff <= word_mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* src/mtbd_mul_unit.sv */
`timescale 1ns / 1ps
module mtbd_mul_unit
   import mtbd_pkg::*;
(
   input  logic        clock,
   input  mul_req_type req,
   output logic [31:0] product
);

   logic [31:0] coef;
   logic [31:0] folded;
   logic [31:0] prod_in;
   logic [31:0] prod_ff;

   always_comb begin
      case (req.sel)
         COEF_SEED: coef = SEED_MULT;
         COEF_KEY:  coef = KEY_MULT;
         COEF_MIX:  coef = MIX_MULT;
         default:   coef = SEED_MULT;
      endcase
   end

   // Every seeding recurrence multiplies p ^ (p >> 30) by a constant, modulo 2^32.
   assign folded = req.word ^ (req.word >> 30);
   assign prod_in = folded * coef;

   always_ff @(posedge clock) begin
      if (req.load) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

/* src/mt19937_bounded_draw.sv */
`timescale 1ns / 1ps
`include "mt19937_bounded_draw_defines.svh"
// MT19937 generator with a bounded draw. A transaction is taken when start is high and busy
// is low; its single result appears for exactly one cycle with rsp_strobe, and the receiver
// must take it then. A draw whose limit is zero, or a draw before any restart, keeps busy low
// and returns its result in the next cycle. Any other draw keeps busy high while it consumes
// generator words, one after another (more than half the draws need just one); each word
// costs a registered read of the word memory followed by a twist and temper step. A restart
// rewrites all 624 state words through one shared multiplier, one word at a time, and busy
// stays high until it is done; array seeding then mixes the key in over two further passes.
// The seed registers may be written only while no transaction is in flight.
module mt19937_bounded_draw
   import mtbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_strobe,
   output rsp_data_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_SD_INIT  = 11'b000_0000_0010,
      ST_SD_MUL   = 11'b000_0000_0100,
      ST_SD_ADD   = 11'b000_0000_1000,
      ST_AR_MUL   = 11'b000_0001_0000,
      ST_AR_UPD   = 11'b000_0010_0000,
      ST_AR_WRAP  = 11'b000_0100_0000,
      ST_AR_FIN   = 11'b000_1000_0000,
      ST_DR_READ  = 11'b001_0000_0000,
      ST_DR_TWIST = 11'b010_0000_0000,
      ST_DR_CHECK = 11'b100_0000_0000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MT_N - 1);

   state_type        state_ff, state_in;
   logic [31:0]      seed_value_ff, seed_value_in;
   logic             seed_mode_ff, seed_mode_in;
   logic             seeded_ff, seeded_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic             phase_ff, phase_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_data_type     rsp_data_ff, rsp_data_in;
   logic [31:0]      prev_ff, prev_in;
   logic [31:0]      cache_ff, cache_in;
   logic [31:0]      word_ff, word_in;
   logic [31:0]      limit_ff, limit_in;
   logic [31:0]      mask_ff, mask_in;

   logic             accept;
   logic             csr_write;
   logic [IDX_W-1:0] pos_next;
   logic [IDX_W-1:0] pos_far;
   logic [IDX_W-1:0] rd_addr_a;
   logic [31:0]      rd_data_a;
   logic [31:0]      rd_data_b;
   logic [31:0]      product;
   logic [31:0]      mixed;
   logic [31:0]      twisted;
   logic [31:0]      candidate;
   ram_wr_type       ram_wr;
   mul_req_type      mul_req;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SEED_MODE) ? {31'd0, seed_mode_ff} : seed_value_ff;

   assign pos_next = (pos_ff == LAST_POS) ? '0 : pos_ff + IDX_W'(1);
   assign pos_far = (pos_ff >= IDX_W'(MT_NM)) ? pos_ff - IDX_W'(MT_NM) : pos_ff + IDX_W'(MT_M);
   // Array seeding reads the word it updates; a draw reads the word after the current one.
   assign rd_addr_a = (state_ff == ST_AR_MUL) ? pos_ff : pos_next;

   assign mixed = rd_data_a ^ product;
   assign twisted = twist_word(cache_ff, rd_data_a, rd_data_b);
   assign candidate = temper(word_ff) & mask_ff;

   mtbd_word_ram u_word_ram (
      .clock     (clock),
      .wr        (ram_wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (pos_far),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mtbd_mul_unit u_mul_unit (
      .clock   (clock),
      .req     (mul_req),
      .product (product)
   );

   always_comb begin
      state_in = state_ff;
      seed_value_in = seed_value_ff;
      seed_mode_in = seed_mode_ff;
      seeded_in = seeded_ff;
      pos_in = pos_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in = rsp_data_ff;
      prev_in = prev_ff;
      cache_in = cache_ff;
      word_in = word_ff;
      limit_in = limit_ff;
      mask_in = mask_ff;
      ram_wr = '{en: 1'b0, addr: pos_ff, data: prev_ff};
      mul_req = '{load: 1'b0, sel: COEF_SEED, word: prev_ff};

      if (csr_write) begin
         if (paddr[2] == REG_SEED_MODE) begin
            seed_mode_in = pwdata[0];
         end else begin
            seed_value_in = pwdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               limit_in = req_data.limit;
               mask_in = cover_mask(req_data.limit);
               if (req_data.func == FUNC_RESTART) begin
                  state_in = ST_SD_INIT;
               end else if (!seeded_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in = '{value: 32'd0, status: STATUS_UNSEEDED};
               end else if (req_data.limit == 32'd0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in = '{value: 32'd0, status: STATUS_OK};
               end else begin
                  state_in = ST_DR_READ;
               end
            end
         end
         ST_SD_INIT: begin
            ram_wr.en = 1'b1;
            ram_wr.addr = '0;
            ram_wr.data = (seed_mode_ff == SEED_ARRAY) ? ARRAY_INIT_SEED : seed_value_ff;
            prev_in = ram_wr.data;
            cache_in = ram_wr.data;
            pos_in = IDX_W'(1);
            state_in = ST_SD_MUL;
         end
         ST_SD_MUL: begin
            mul_req.load = 1'b1;
            mul_req.sel = COEF_SEED;
            state_in = ST_SD_ADD;
         end
         ST_SD_ADD: begin
            ram_wr.en = 1'b1;
            ram_wr.data = product + 32'(pos_ff);
            prev_in = ram_wr.data;
            if (pos_ff != LAST_POS) begin
               pos_in = pos_next;
               state_in = ST_SD_MUL;
            end else if (seed_mode_ff == SEED_ARRAY) begin
               // The key mixing starts again from word 0, which still holds the fixed seed.
               prev_in = ARRAY_INIT_SEED;
               pos_in = IDX_W'(1);
               count_in = IDX_W'(MT_N);
               phase_in = 1'b0;
               state_in = ST_AR_MUL;
            end else begin
               pos_in = '0;
               seeded_in = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_data_in = '{value: 32'd0, status: STATUS_OK};
               state_in = ST_IDLE;
            end
         end
         ST_AR_MUL: begin
            mul_req.load = 1'b1;
            mul_req.sel = phase_ff ? COEF_MIX : COEF_KEY;
            state_in = ST_AR_UPD;
         end
         ST_AR_UPD: begin
            ram_wr.en = 1'b1;
            ram_wr.data = phase_ff ? mixed - 32'(pos_ff) : mixed + seed_value_ff;
            prev_in = ram_wr.data;
            count_in = count_ff - IDX_W'(1);
            if (pos_ff == LAST_POS) begin
               state_in = ST_AR_WRAP;
            end else begin
               pos_in = pos_next;
               if (count_ff == IDX_W'(1)) begin
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                     count_in = IDX_W'(MT_N - 1);
                     state_in = ST_AR_MUL;
                  end else begin
                     state_in = ST_AR_FIN;
                  end
               end else begin
                  state_in = ST_AR_MUL;
               end
            end
         end
         ST_AR_WRAP: begin
            // Word 0 takes a copy of the last word, and the sweep restarts at word 1.
            ram_wr.en = 1'b1;
            ram_wr.addr = '0;
            ram_wr.data = prev_ff;
            cache_in = prev_ff;
            pos_in = IDX_W'(1);
            if (count_ff == '0) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  count_in = IDX_W'(MT_N - 1);
                  state_in = ST_AR_MUL;
               end else begin
                  state_in = ST_AR_FIN;
               end
            end else begin
               state_in = ST_AR_MUL;
            end
         end
         ST_AR_FIN: begin
            ram_wr.en = 1'b1;
            ram_wr.addr = '0;
            ram_wr.data = UPPER_MASK;
            cache_in = UPPER_MASK;
            pos_in = '0;
            seeded_in = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_data_in = '{value: 32'd0, status: STATUS_OK};
            state_in = ST_IDLE;
         end
         ST_DR_READ: begin
            state_in = ST_DR_TWIST;
         end
         ST_DR_TWIST: begin
            // Twisting each word in place just before it is used gives the same sequence
            // as twisting the whole block at once. cache_ff always holds the current word.
            ram_wr.en = 1'b1;
            ram_wr.data = twisted;
            word_in = twisted;
            cache_in = rd_data_a;
            pos_in = pos_next;
            state_in = ST_DR_CHECK;
         end
         ST_DR_CHECK: begin
            if (candidate <= limit_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in = '{value: candidate, status: STATUS_OK};
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DR_TWIST;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seed_value_ff <= '0;
         seed_mode_ff <= SEED_SINGLE;
         seeded_ff <= 1'b0;
         pos_ff <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_value_ff <= seed_value_in;
         seed_mode_ff <= seed_mode_in;
         seeded_ff <= seeded_in;
         pos_ff <= pos_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      prev_ff <= prev_in;
      cache_ff <= cache_in;
      word_ff <= word_in;
      limit_ff <= limit_in;
      mask_ff <= mask_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

   `MTBD_ASSERT_SAME(a_strobe_when_idle, rsp_strobe, !busy, "result strobe while sequencer busy")
   `MTBD_ASSERT_NEXT(a_accept_progress, accept, rsp_strobe || busy, "transaction was dropped")
   `MTBD_ASSERT_SAME(a_value_in_range, rsp_strobe, rsp_data.value <= limit_ff,
                     "drawn value exceeds the limit")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
import mtbd_pkg::*;

class mt_draw_scoreboard;
   logic [31:0]  seed_word;
   logic         seed_mode_bit;
   logic [31:0]  words [MT_N];
   int           word_ptr;
   bit           seeded;
   rsp_data_type expected_results [$];
   int           errors;

   function new();
      seed_word = '0;
      seed_mode_bit = SEED_SINGLE;
      foreach (words[n]) words[n] = '0;
      word_ptr = 0;
      seeded = 1'b0;
      errors = 0;
   endfunction

   function void set_register(logic idx, logic [31:0] data);
      if (idx == REG_SEED_VALUE) seed_word = data;
      else seed_mode_bit = data[0];
   endfunction

   function int pending();
      return expected_results.size();
   endfunction

   function void load_single_seed(logic [31:0] s);
      logic [31:0] p;
      int unsigned i;
      words[0] = s;
      for (i = 1; i < MT_N; i++) begin
         p = words[i-1];
         words[i] = SEED_MULT * (p ^ (p >> 30)) + i;
      end
      word_ptr = MT_N;
   endfunction

   function void load_key_seed(logic [31:0] key);
      logic [31:0] p;
      int unsigned i;
      int          k;
      load_single_seed(ARRAY_INIT_SEED);
      i = 1;
      for (k = MT_N; k > 0; k--) begin
         p = words[i-1];
         words[i] = (words[i] ^ ((p ^ (p >> 30)) * KEY_MULT)) + key;
         i++;
         if (i >= MT_N) begin
            words[0] = words[MT_N-1];
            i = 1;
         end
      end
      for (k = MT_N - 1; k > 0; k--) begin
         p = words[i-1];
         words[i] = (words[i] ^ ((p ^ (p >> 30)) * MIX_MULT)) - i;
         i++;
         if (i >= MT_N) begin
            words[0] = words[MT_N-1];
            i = 1;
         end
      end
      words[0] = UPPER_MASK;
      word_ptr = MT_N;
   endfunction

   // Indexing modulo the state size gives the same order of updates as the
   // three-segment form: the last word sees the already refreshed words 0 and M-1.
   function void regenerate_block();
      logic [31:0] y;
      int          k;
      for (k = 0; k < MT_N; k++) begin
         y = {words[k][31], words[(k + 1) % MT_N][30:0]};
         words[k] = words[(k + MT_M) % MT_N] ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
      end
      word_ptr = 0;
   endfunction

   function logic [31:0] next_output();
      logic [31:0] w;
      if (word_ptr >= MT_N) regenerate_block();
      w = words[word_ptr];
      word_ptr++;
      w = w ^ (w >> 11);
      w = w ^ ((w << 7) & TEMPER_B);
      w = w ^ ((w << 15) & TEMPER_C);
      return w ^ (w >> 18);
   endfunction

   function logic [31:0] limit_span(logic [31:0] lim);
      logic [31:0] m;
      int          b;
      m = '0;
      for (b = 0; b < 32; b++)
         if (lim[b]) m = {32{1'b1}} >> (31 - b);
      return m;
   endfunction

   function rsp_data_type predict_draw(req_data_type item);
      rsp_data_type e;
      logic [31:0]  m;
      logic [31:0]  v;
      e.value = '0;
      e.status = STATUS_OK;
      if (item.func == FUNC_RESTART) begin
         if (seed_mode_bit == SEED_ARRAY) load_key_seed(seed_word);
         else load_single_seed(seed_word);
         seeded = 1'b1;
      end else if (!seeded) begin
         e.status = STATUS_UNSEEDED;
      end else if (item.limit != 0) begin
         m = limit_span(item.limit);
         do v = next_output() & m; while (v > item.limit);
         e.value = v;
      end
      return e;
   endfunction

   function void note_request(req_data_type item);
      expected_results.push_back(predict_draw(item));
   endfunction

   task report_mismatch(string what);
      // Printing stops after a while so a broken block cannot flood the log.
      if (errors < 100) $display("%0t error: %s", $time, what);
      errors++;
   endtask

   task check_result(rsp_data_type got);
      rsp_data_type e;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result value=%h status=%b",
                                   got.value, got.status));
      end else begin
         e = expected_results.pop_front();
         if (got.value !== e.value)
            report_mismatch($sformatf("value %h, expected %h", got.value, e.value));
         if (got.status !== e.status)
            report_mismatch($sformatf("status %b, expected %b", got.status, e.status));
      end
   endtask
endclass

module testbench;
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_data_type req_data = '0;
   logic         rsp_strobe;
   rsp_data_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   mt_draw_scoreboard draws;
   int                burst_left;

   mt19937_bounded_draw DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) draws.check_result(rsp_data);
   end

   task automatic send_item(input req_data_type item);
      req_data <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      draws.note_request(item);
   endtask

   task automatic send(input logic func, input logic [31:0] limit);
      req_data_type item;
      item.func = func;
      item.limit = limit;
      send_item(item);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (draws.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      draws.set_register(idx, data);
   endtask

   function automatic logic [31:0] random_limit();
      int unsigned k;
      k = $urandom_range(0, 31);
      case ($urandom_range(0, 6))
         0: return $urandom;
         1: return $urandom_range(0, 16);
         2: return 32'h1 << k;
         3: return (32'h1 << k) - 1;
         4: return (32'h1 << k) + 1;
         5: return $urandom >> k;
         default: return 32'hffffffff - $urandom_range(0, 3);
      endcase
   endfunction

   // Each phase opens with a restart; later restarts are rare so long runs
   // of draws come between them.
   task automatic run_phase(input logic [31:0] seed, input logic mode, input int count);
      req_data_type item;
      int           n;
      wait_drained();
      write_register(REG_SEED_VALUE, seed);
      write_register(REG_SEED_MODE, {31'd0, mode});
      for (n = 0; n < count; n++) begin
         item.func = (n == 0 || $urandom_range(0, 149) == 0) ? FUNC_RESTART : FUNC_DRAW;
         item.limit = random_limit();
         send_item(item);
         if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 5);
         end else begin
            burst_left--;
         end
      end
   endtask

   initial begin
      draws = new();
      burst_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Draws before any restart must report the unseeded status.
      send(FUNC_DRAW, 32'h0);
      send(FUNC_DRAW, 32'hffffffff);
      send(FUNC_DRAW, 32'h5a5a5a5a);
      // Restart from the reset value of the seed registers; the limit is ignored.
      send(FUNC_RESTART, 32'hffffffff);
      send(FUNC_DRAW, 32'h0);
      send(FUNC_DRAW, 32'hffffffff);
      send(FUNC_DRAW, 32'h1);
      send(FUNC_DRAW, 32'h2);
      send(FUNC_DRAW, 32'h3);
      send(FUNC_DRAW, 32'h80000000);
      send(FUNC_DRAW, 32'h7fffffff);
      send(FUNC_DRAW, 32'h80000001);
      send(FUNC_DRAW, 32'hfffffffe);
      send(FUNC_DRAW, 32'h0);
      wait_drained();
      write_register(REG_SEED_VALUE, 32'hffffffff);
      write_register(REG_SEED_MODE, {31'd0, SEED_ARRAY});
      send(FUNC_RESTART, 32'h0);
      send(FUNC_DRAW, 32'hffffffff);
      send(FUNC_DRAW, 32'h1);
      send(FUNC_DRAW, 32'h80000000);
      send(FUNC_DRAW, 32'h0);
      send(FUNC_DRAW, 32'h00000100);

      run_phase(32'h0, SEED_SINGLE, 280);
      run_phase(32'hffffffff, SEED_ARRAY, 280);
      run_phase(32'd5489, SEED_SINGLE, 280);
      run_phase($urandom, SEED_ARRAY, 280);
      run_phase(32'h0, SEED_ARRAY, 280);
      run_phase(32'hffffffff, SEED_SINGLE, 280);
      run_phase($urandom, $urandom_range(0, 1), 280);

      start <= 1'b0;
      while (draws.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (draws.errors == 0 && draws.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
